FILE: src/hba_pkg.sv
// Shared constants and operation codes for the histogram bin accumulator.
package hba_pkg;

	// Default storage sizes.
	localparam int NUM_BINS_DEF   = 64;
	localparam int COUNT_BITS_DEF = 32;

	// Fixed field widths.
	localparam int DATA_W     = 32;
	localparam int WIDTH_W    = 31;
	localparam int BINS_W     = 7;
	localparam int OP_W       = 2;
	localparam int OUT_IDX_W  = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int DIV_STEPS  = 32;
	localparam int STEP_W     = 5;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ   = 2'd2;
	localparam logic [OP_W-1:0] OP_PEAK   = 2'd3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_LOW_EDGE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_EDGE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 2'd3;

	// Register reset values.
	localparam logic [DATA_W-1:0]  LOW_EDGE_RST    = 32'd0;
	localparam logic [DATA_W-1:0]  HIGH_EDGE_RST   = 32'd131072;
	localparam logic [WIDTH_W-1:0] BIN_WIDTH_RST   = 31'd3277;
	localparam logic [BINS_W-1:0]  BINS_IN_USE_RST = 7'd40;

endpackage

FILE: src/histogram_bin_accumulator.sv
// Top level of the uniform-width histogram with a shared divider and bin-count memory.
//
//  channel   direction   signals
//  in        sink        in_valid, in_ready, op, sample, read_index
//  out       source      out_valid, out_ready, applied, bin_index, bin_count, bin_center
//  cfg       sink        cfg_valid, cfg_ready, cfg_index, cfg_data
//
// Add and remove items run the check, the one-bit-per-cycle restoring divider that finds
// the bin, then memory read, update and center. A read item checks the index and reads
// the memory; a peak item does one memory read per bin in use, then rereads the best bin.
// After reset a clearing pass writes zero to all NUM_BINS entries, one per cycle, and
// in_ready stays low until it ends. Configuration writes are always taken.
// A finished item waits in the output register, so a stalled output holds only the last step.
module histogram_bin_accumulator
	import hba_pkg::*;
#(
	parameter int NUM_BINS   = NUM_BINS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [OP_W-1:0]             op,
	input  logic signed [DATA_W-1:0]    sample,
	input  logic [OUT_IDX_W-1:0]        read_index,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        applied,
	output logic [OUT_IDX_W-1:0]        bin_index,
	output logic signed [DATA_W-1:0]    bin_count,
	output logic signed [DATA_W-1:0]    bin_center,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [DATA_W-1:0]           cfg_data
);

	localparam int IDX_W  = $clog2(NUM_BINS);
	localparam int CNTN_W = $clog2(NUM_BINS + 1);
	localparam int NB_W   = (CNTN_W > BINS_W) ? CNTN_W : BINS_W;

	// Sequencer state codes.
	localparam logic [3:0] ST_CLEAR    = 4'd0;
	localparam logic [3:0] ST_IDLE     = 4'd1;
	localparam logic [3:0] ST_CHECK    = 4'd2;
	localparam logic [3:0] ST_DIV      = 4'd3;
	localparam logic [3:0] ST_CLAMP    = 4'd4;
	localparam logic [3:0] ST_RD       = 4'd5;
	localparam logic [3:0] ST_UPD      = 4'd6;
	localparam logic [3:0] ST_CTR      = 4'd7;
	localparam logic [3:0] ST_SCAN     = 4'd8;
	localparam logic [3:0] ST_SCAN_END = 4'd9;
	localparam logic [3:0] ST_FINISH   = 4'd10;

	localparam logic signed [COUNT_BITS-1:0] CNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
	localparam logic signed [COUNT_BITS-1:0] CNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};

	// Configuration registers.
	logic signed [DATA_W-1:0] low_edge_q;
	logic signed [DATA_W-1:0] high_edge_q;
	logic [WIDTH_W-1:0]       bin_width_q;
	logic [BINS_W-1:0]        bins_in_use_q;

	// Sequencer and datapath registers.
	logic [3:0]                     state_q;
	logic [OP_W-1:0]                op_q;
	logic signed [DATA_W-1:0]       sample_q;
	logic [OUT_IDX_W-1:0]           read_index_q;
	logic [IDX_W-1:0]               addr_q;
	logic [DATA_W-1:0]              rem_q;
	logic [DATA_W-1:0]              quo_q;
	logic [STEP_W-1:0]              step_q;
	logic signed [COUNT_BITS-1:0]   count_q;
	logic [DATA_W-1:0]              mult_q;
	logic [DATA_W-1:0]              center_q;
	logic                           zero_q;
	logic                           ok_q;
	logic signed [COUNT_BITS-1:0]   top_q;
	logic [IDX_W-1:0]               best_q;
	logic                           issue_done_q;
	logic                           cmp_v_s1;
	logic                           cmp_last_s1;
	logic [IDX_W-1:0]               cmp_idx_s1;

	// Output register.
	logic                           out_valid_q;
	logic                           applied_q;
	logic [OUT_IDX_W-1:0]           bin_index_q;
	logic signed [DATA_W-1:0]       bin_count_q;
	logic signed [DATA_W-1:0]       bin_center_q;

	// Bin-count memory.
	logic signed [COUNT_BITS-1:0]   mem [NUM_BINS];
	logic signed [COUNT_BITS-1:0]   rd_data_q;
	logic                           mem_we;
	logic signed [COUNT_BITS-1:0]   mem_wd;

	// Combinational helpers.
	logic [NB_W-1:0]                nb;
	logic [DATA_W-1:0]              div_trial;
	logic [DATA_W-1:0]              div_sub;
	logic                           div_ge;
	logic                           scan_last;
	logic signed [COUNT_BITS-1:0]   count_next;
	logic                           is_update;

	assign cfg_ready  = 1'b1;
	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;
	assign applied    = applied_q;
	assign bin_index  = bin_index_q;
	assign bin_count  = bin_count_q;
	assign bin_center = bin_center_q;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_edge_q    <= LOW_EDGE_RST;
			high_edge_q   <= HIGH_EDGE_RST;
			bin_width_q   <= BIN_WIDTH_RST;
			bins_in_use_q <= BINS_IN_USE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_LOW_EDGE:    low_edge_q    <= cfg_data;
				REG_HIGH_EDGE:   high_edge_q   <= cfg_data;
				REG_BIN_WIDTH:   bin_width_q   <= cfg_data[WIDTH_W-1:0];
				REG_BINS_IN_USE: bins_in_use_q <= cfg_data[BINS_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective bin count: bins_in_use clamped to one through NUM_BINS.
	always_comb begin
		if (bins_in_use_q == '0) begin
			nb = NB_W'(1);
		end else if (NB_W'(bins_in_use_q) > NB_W'(NUM_BINS)) begin
			nb = NB_W'(NUM_BINS);
		end else begin
			nb = NB_W'(bins_in_use_q);
		end
	end

	// One restoring division step: shift in the next dividend bit and try the subtract.
	assign div_trial = {rem_q[DATA_W-2:0], quo_q[DATA_W-1]};
	assign div_ge    = div_trial >= {1'b0, bin_width_q};
	assign div_sub   = div_trial - {1'b0, bin_width_q};

	assign scan_last = (NB_W'(addr_q) == nb - NB_W'(1));
	assign is_update = (op_q == OP_ADD) || (op_q == OP_REMOVE);

	// Saturating increment or decrement of the count just read.
	always_comb begin
		count_next = rd_data_q;
		if (op_q == OP_ADD) begin
			if (rd_data_q != CNT_MAX) begin
				count_next = rd_data_q + COUNT_BITS'(1);
			end
		end else if (rd_data_q != CNT_MIN) begin
			count_next = rd_data_q - COUNT_BITS'(1);
		end
	end

	// Memory write port: zero during the clearing pass, the new count on an update.
	always_comb begin
		mem_we = 1'b0;
		mem_wd = '0;
		if (state_q == ST_CLEAR) begin
			mem_we = 1'b1;
		end else if (state_q == ST_UPD && is_update) begin
			mem_we = 1'b1;
			mem_wd = count_next;
		end
	end

	// Bin-count memory with one write port and a registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[addr_q] <= mem_wd;
		end
		rd_data_q <= mem[addr_q];
	end

	// Sequencer and datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			op_q         <= OP_ADD;
			sample_q     <= '0;
			read_index_q <= '0;
			addr_q       <= '0;
			rem_q        <= '0;
			quo_q        <= '0;
			step_q       <= '0;
			count_q      <= '0;
			mult_q       <= '0;
			center_q     <= '0;
			zero_q       <= 1'b0;
			ok_q         <= 1'b0;
			top_q        <= '0;
			best_q       <= '0;
			issue_done_q <= 1'b0;
			cmp_v_s1     <= 1'b0;
			cmp_last_s1  <= 1'b0;
			cmp_idx_s1   <= '0;
			out_valid_q  <= 1'b0;
			applied_q    <= 1'b0;
			bin_index_q  <= '0;
			bin_count_q  <= '0;
			bin_center_q <= '0;
		end else begin
			// A taken result frees the output register unless a new one replaces it.
			if (out_valid_q && out_ready && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				// Sweep the whole memory to zero after reset.
				ST_CLEAR: begin
					if (addr_q == IDX_W'(NUM_BINS - 1)) begin
						addr_q  <= '0;
						state_q <= ST_IDLE;
					end else begin
						addr_q <= addr_q + IDX_W'(1);
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q         <= op;
						sample_q     <= sample;
						read_index_q <= read_index;
						state_q      <= ST_CHECK;
					end
				end
				// Range and index checks, and setup of the divider or the scan.
				ST_CHECK: begin
					case (op_q)
						OP_READ: begin
							if (NB_W'(read_index_q) >= nb) begin
								zero_q  <= 1'b1;
								ok_q    <= 1'b0;
								state_q <= ST_FINISH;
							end else begin
								zero_q  <= 1'b0;
								ok_q    <= 1'b1;
								addr_q  <= IDX_W'(read_index_q);
								state_q <= ST_RD;
							end
						end
						OP_PEAK: begin
							zero_q       <= 1'b0;
							addr_q       <= '0;
							top_q        <= '0;
							best_q       <= '0;
							ok_q         <= 1'b0;
							issue_done_q <= 1'b0;
							cmp_v_s1     <= 1'b0;
							state_q      <= ST_SCAN;
						end
						default: begin
							if (bin_width_q == '0 || sample_q < low_edge_q ||
							    sample_q > high_edge_q) begin
								zero_q  <= 1'b1;
								ok_q    <= 1'b0;
								state_q <= ST_FINISH;
							end else begin
								zero_q  <= 1'b0;
								ok_q    <= 1'b1;
								rem_q   <= '0;
								quo_q   <= $unsigned(sample_q - low_edge_q);
								step_q  <= '0;
								state_q <= ST_DIV;
							end
						end
					endcase
				end
				// One quotient bit per cycle.
				ST_DIV: begin
					rem_q <= div_ge ? div_sub : div_trial;
					quo_q <= {quo_q[DATA_W-2:0], div_ge};
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(DIV_STEPS - 1)) begin
						state_q <= ST_CLAMP;
					end
				end
				// A quotient at or past the last bin lands in the last bin.
				ST_CLAMP: begin
					if (quo_q >= DATA_W'(nb)) begin
						addr_q <= IDX_W'(nb - NB_W'(1));
					end else begin
						addr_q <= IDX_W'(quo_q);
					end
					state_q <= ST_RD;
				end
				ST_RD: begin
					state_q <= ST_UPD;
				end
				// Count update or capture, and the index product for the center.
				ST_UPD: begin
					count_q <= is_update ? count_next : rd_data_q;
					mult_q  <= DATA_W'({1'b0, bin_width_q}) * DATA_W'(addr_q);
					state_q <= ST_CTR;
				end
				ST_CTR: begin
					center_q <= $unsigned(low_edge_q) + DATA_W'(bin_width_q >> 1) + mult_q;
					state_q  <= ST_FINISH;
				end
				// Peak search: issue one read per cycle, compare each read in the cycle after it.
				ST_SCAN: begin
					if (!issue_done_q) begin
						cmp_v_s1    <= 1'b1;
						cmp_last_s1 <= scan_last;
						cmp_idx_s1  <= addr_q;
						if (scan_last) begin
							issue_done_q <= 1'b1;
						end else begin
							addr_q <= addr_q + IDX_W'(1);
						end
					end else begin
						cmp_v_s1 <= 1'b0;
					end
					if (cmp_v_s1) begin
						if (rd_data_q > top_q) begin
							top_q  <= rd_data_q;
							best_q <= cmp_idx_s1;
							ok_q   <= 1'b1;
						end
						if (cmp_last_s1) begin
							state_q <= ST_SCAN_END;
						end
					end
				end
				ST_SCAN_END: begin
					addr_q  <= best_q;
					state_q <= ST_RD;
				end
				// Hand the result to the output register once it is free.
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						applied_q   <= ok_q;
						if (zero_q) begin
							bin_index_q  <= '0;
							bin_count_q  <= '0;
							bin_center_q <= '0;
						end else begin
							bin_index_q  <= OUT_IDX_W'(addr_q);
							bin_count_q  <= DATA_W'(count_q);
							bin_center_q <= center_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
